FILE: design/sadt_pkg.sv
package sadt_pkg;

	localparam int TABLE_DEPTH     = 128;
	localparam int IDX_W           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);
	localparam int TYPE_W          = 8;
	localparam int ADDR_W          = 48;
	localparam int ENTRY_W         = TYPE_W + ADDR_W;
	localparam int COUNT_FIELD_W   = 8;
	localparam int COUNT_FIELD_MAX = (1 << COUNT_FIELD_W) - 1;

	typedef struct packed {
		logic [TYPE_W-1:0] addr_type;
		logic [ADDR_W-1:0] addr_value;
	} sadt_in_t;

	typedef struct packed {
		logic                     is_new;
		logic                     was_stored;
		logic [COUNT_FIELD_W-1:0] entry_count;
	} sadt_out_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} sadt_rd_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [ENTRY_W-1:0] data;
	} sadt_wr_t;

endpackage

FILE: design/seen_address_dedup_table.sv
// Duplicate address filter. Each beat on item carries an address type and a
// 48-bit address; the block scans the stored entries in order through one
// table read port and one 56-bit comparator, one entry per cycle, and stops
// at the first match. A new address is compared with every stored entry;
// a duplicate ends the scan at the entry that matches it. item_stall stays
// high from the taking of an item until its result is registered, and
// longer while a finished result waits for the result register to free.
// New addresses are appended while there is room;
// a full table still reports them as new without storing them. Nothing is
// ever evicted; only reset empties the table. The result register lets the
// next item be taken while a result waits on result_stall.
module seen_address_dedup_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  sadt_pkg::sadt_in_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output sadt_pkg::sadt_out_t result
);
	import sadt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] iss_q;
	logic             hit_q;
	logic             rd_valid_s1;
	logic             last_s1;
	logic             result_valid_q;
	sadt_out_t        result_q;
	sadt_in_t         key_q;

	sadt_rd_t         rd;
	sadt_wr_t         wr;
	logic             hit;
	logic             issue;
	logic             out_free;
	logic             room;
	logic             store;
	logic [CNT_W-1:0] next_count;
	logic [COUNT_FIELD_W-1:0] shown;

	assign out_free = !result_valid_q || !result_stall;
	assign room     = (count_q < CNT_W'(TABLE_DEPTH));
	assign store    = !hit_q && room;
	assign issue    = (state_q == ST_SCAN) && (iss_q < count_q)
		&& !(rd_valid_s1 && (hit || last_s1));

	assign rd.en   = issue;
	assign rd.addr = iss_q[IDX_W-1:0];

	assign wr.en   = (state_q == ST_DONE) && out_free && store;
	assign wr.addr = count_q[IDX_W-1:0];
	assign wr.data = key_q;

	always_comb begin
		next_count = store ? count_q + CNT_W'(1) : count_q;
		if (32'(next_count) > COUNT_FIELD_MAX) begin
			shown = COUNT_FIELD_W'(COUNT_FIELD_MAX);
		end else begin
			shown = COUNT_FIELD_W'(next_count);
		end
	end

	sadt_store u_store (
		.clk (clk),
		.wr  (wr),
		.rd  (rd),
		.key (key_q),
		.hit (hit)
	);

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && item_valid) begin
			key_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			iss_q          <= '0;
			hit_q          <= 1'b0;
			rd_valid_s1    <= 1'b0;
			last_s1        <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			rd_valid_s1 <= issue;
			last_s1     <= (iss_q == count_q - CNT_W'(1));
			if ((state_q == ST_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						iss_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= (count_q == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					if (rd_valid_s1 && hit) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (rd_valid_s1 && last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result_q.is_new      <= !hit_q;
						result_q.was_stored  <= store;
						result_q.entry_count <= shown;
						count_q              <= next_count;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		rd.en |-> (iss_q < count_q))
		else $error("read of an unwritten entry");

	a_stored_is_new: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.is_new || !result_q.was_stored))
		else $error("duplicate reported as stored");
`endif

endmodule

FILE: design/sadt_store.sv
module sadt_store (
	input  logic                     clk,
	input  sadt_pkg::sadt_wr_t       wr,
	input  sadt_pkg::sadt_rd_t       rd,
	input  logic [sadt_pkg::ENTRY_W-1:0] key,
	output logic                     hit
);
	import sadt_pkg::*;

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign hit = (rd_data_q == key);

endmodule

FILE: sim/seen_address_dedup_table_checker.sv
module seen_address_dedup_table_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  sadt_pkg::sadt_in_t  item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  sadt_pkg::sadt_out_t result,
	output int                  mismatches,
	output int                  outstanding,
	output int                  beats_checked,
	output int                  duplicates,
	output int                  dropped
);
	import sadt_pkg::*;

	logic [ENTRY_W-1:0] mirror_entries [TABLE_DEPTH];
	int unsigned        mirror_used;
	sadt_out_t          expected_verdicts [$];

	function automatic sadt_out_t search_and_append(sadt_in_t b);
		logic [ENTRY_W-1:0] key;
		bit                 hit;
		sadt_out_t          v;
		key = {b.addr_type, b.addr_value};
		hit = 1'b0;
		for (int i = 0; i < mirror_used; i++) begin
			if (mirror_entries[i] == key)
				hit = 1'b1;
		end
		v.is_new = !hit;
		v.was_stored = 1'b0;
		if (!hit && mirror_used < TABLE_DEPTH) begin
			mirror_entries[mirror_used] = key;
			mirror_used++;
			v.was_stored = 1'b1;
		end
		v.entry_count = COUNT_FIELD_W'((mirror_used > COUNT_FIELD_MAX) ?
			COUNT_FIELD_MAX : mirror_used);
		return v;
	endfunction

	task automatic compare_field(input string name, input logic [COUNT_FIELD_W-1:0] want,
			input logic [COUNT_FIELD_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sadt_out_t want;
		if (!arst_n) begin
			expected_verdicts.delete();
			mirror_used = 0;
			outstanding = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected, expected none, actual %p",
						$time, result);
				end else begin
					want = expected_verdicts.pop_front();
					compare_field("is_new", want.is_new, result.is_new);
					compare_field("was_stored", want.was_stored, result.was_stored);
					compare_field("entry_count", want.entry_count, result.entry_count);
					beats_checked++;
					if (!want.is_new)
						duplicates++;
					if (want.is_new && !want.was_stored)
						dropped++;
				end
			end
			if (item_valid && !item_stall)
				expected_verdicts.push_back(search_and_append(item));
			outstanding = expected_verdicts.size();
		end
	end

endmodule

FILE: sim/seen_address_dedup_table_test.sv
module seen_address_dedup_table_test;
	import sadt_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	sadt_in_t  item = '0;
	logic      result_stall = 1'b0;
	logic      item_stall;
	logic      result_valid;
	sadt_out_t result;

	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        mismatches;
	int        outstanding;
	int        beats_checked;
	int        duplicates;
	int        dropped;
	sadt_in_t  sent_log [$];

	seen_address_dedup_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	seen_address_dedup_table_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.beats_checked (beats_checked),
		.duplicates    (duplicates),
		.dropped       (dropped)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_beat(input sadt_in_t b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= b;
		sent_log.push_back(b);
		do @(posedge clk); while (item_stall);
	endtask

	task automatic random_beat();
		sadt_in_t b;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 45 && sent_log.size() > 0) begin
			b = sent_log[$urandom_range(sent_log.size() - 1)];
		end else if (pick < 55 && sent_log.size() > 0) begin
			b = sent_log[$urandom_range(sent_log.size() - 1)];
			b = sadt_in_t'(b ^ (ENTRY_W'(1) << $urandom_range(ENTRY_W - 1)));
		end else begin
			b.addr_type = $urandom_range(1) ? TYPE_W'($urandom_range(1)) : TYPE_W'($urandom);
			b.addr_value = ADDR_W'({$urandom, $urandom});
		end
		send_beat(b);
	endtask

	initial begin
		send_idle_pct = 31;
		recv_stall_pct = 82;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		send_beat('{8'h00, 48'h0000_0000_0000});
		send_beat('{8'h00, 48'h0000_0000_0000});
		send_beat('{8'hFF, 48'hFFFF_FFFF_FFFF});
		send_beat('{8'hFF, 48'hFFFF_FFFF_FFFF});
		send_beat('{8'h00, 48'hFFFF_FFFF_FFFF});
		send_beat('{8'hFF, 48'h0000_0000_0000});
		send_beat('{8'h01, 48'h0000_0000_0000});
		send_beat('{8'h00, 48'h0000_0000_0001});
		send_beat('{8'h80, 48'h8000_0000_0000});
		send_beat('{8'h7F, 48'h7FFF_FFFF_FFFF});
		send_beat('{8'hAA, 48'hAAAA_AAAA_AAAA});
		send_beat('{8'h55, 48'h5555_5555_5555});
		send_beat('{8'h00, 48'h0000_0000_0000});
		send_beat('{8'h55, 48'h5555_5555_5555});
		send_beat('{8'h01, 48'h0000_0000_0000});
		send_beat('{8'hFF, 48'hFFFF_FFFF_FFFE});
		send_beat('{8'hFE, 48'hFFFF_FFFF_FFFF});

		repeat (645) random_beat();
		send_idle_pct = 82;
		recv_stall_pct = 31;
		repeat (645) random_beat();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (645) random_beat();

		@(negedge clk);
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (140) @(negedge clk);

		$display("Checked %0d result beats: %0d duplicates, %0d new addresses refused by a full table.",
			beats_checked, duplicates, dropped);
		$display("Idling ran 31/82 percent sender/receiver, then 82/31, then none.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
